/* design/pgtb_pkg.sv */
// ----------------------------------------------------------------------------
// pgtb_pkg
// Shared constants, action codes and controller/datapath interface types of
// the proportional glyph tile blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package pgtb_pkg;

  // font geometry
  localparam int GLYPH_COUNT     = 96;
  localparam int MAX_GLYPH_WIDTH = 8;
  // power of two, so the font address wraps by truncation
  localparam int FONT_DEPTH      = 8192;
  localparam int MAX_ROWS        = 8;
  localparam int PAL_DEPTH       = 16;

  localparam int WIDX_W  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int OIDX_W  = $clog2(GLYPH_COUNT + 1);
  localparam int FONT_AW = $clog2(FONT_DEPTH);
  localparam int WIDTH_W = 4;
  localparam int ROWS_W  = 4;
  localparam int COL_W   = 3;
  localparam int OFF_W   = 10;
  localparam int COLB_W  = 11;
  // widest unreduced font address: 7 rows of strip plus offset plus column
  localparam int RAW_W   = 13;

  // tile memory layout
  localparam int TILE_PITCH    = 320;
  localparam int TILE_COL_STEP = 319;
  localparam int TILE_WRAP     = 9600;
  localparam int CHAR_FIRST    = 32;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // stream widths
  localparam int IN_W  = 56;
  localparam int OUT_W = 32;

  // action codes
  localparam logic [2:0] ACT_LOAD_WIDTH = 3'd0;
  localparam logic [2:0] ACT_LOAD_FONT  = 3'd1;
  localparam logic [2:0] ACT_LOAD_PAL   = 3'd2;
  localparam logic [2:0] ACT_SET_CURSOR = 3'd3;
  localparam logic [2:0] ACT_PRINT      = 3'd4;

  typedef struct packed {
    logic accept;
    logic wr_width;
    logic print_init;
    logic issue;
    logic col_adv;
    logic last;
  } pgtb_cmd_t;

  typedef struct packed {
    logic               width_ok;
    logic               print_ok;
    logic [WIDTH_W-1:0] glyph_w;
    logic [ROWS_W-1:0]  rows;
    logic               room;
  } pgtb_sts_t;

  typedef struct packed {
    logic        last;
    logic [15:0] or_value;
    logic [15:0] addr;
  } pgtb_wr_t;

endpackage

`default_nettype wire

/* design/pgtb_ctrl.sv */
// ----------------------------------------------------------------------------
// pgtb_ctrl
// Sequencer: request decode, width table update and the column/row walk
// over one glyph.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtb_ctrl import pgtb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  pgtb_sts_t sts_i,
  output pgtb_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WIDTH = 2'd1;
  localparam logic [1:0] S_PREP  = 2'd2;
  localparam logic [1:0] S_PRINT = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] row_q, row_d;
  logic             col_end;
  logic             row_end;

  assign col_end   = ({1'b0, col_q} == (sts_i.glyph_w - WIDTH_W'(1)));
  assign row_end   = ({1'b0, row_q} == (sts_i.rows - ROWS_W'(1)));
  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.accept = s_valid_i;
        if (s_valid_i) begin
          if (sts_i.width_ok) begin
            state_d = S_WIDTH;
          end else if (sts_i.print_ok) begin
            state_d = S_PREP;
          end
        end
      end
      S_WIDTH: begin
        cmd_o.wr_width = 1'b1;
        state_d        = S_IDLE;
      end
      S_PREP: begin
        cmd_o.print_init = 1'b1;
        col_d            = '0;
        row_d            = '0;
        state_d          = S_PRINT;
      end
      S_PRINT: begin
        if (sts_i.glyph_w == '0) begin
          state_d = S_IDLE;
        end else if (sts_i.rows == '0) begin
          // zero height: cursor still steps once per column
          cmd_o.col_adv = 1'b1;
          col_d         = col_q + COL_W'(1);
          if (col_end) begin
            state_d = S_IDLE;
          end
        end else if (sts_i.room) begin
          cmd_o.issue = 1'b1;
          cmd_o.last  = col_end && row_end;
          if (row_end) begin
            cmd_o.col_adv = 1'b1;
            row_d         = '0;
            col_d         = col_q + COL_W'(1);
            if (col_end) begin
              state_d = S_IDLE;
            end
          end else begin
            row_d = row_q + COL_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

`ifndef SYNTH
  a_issue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> (state_q == S_PRINT) && sts_i.room)
    else $error("pixel issued without queue room");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("glyph walk continued after last write");

  a_print_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && sts_i.print_ok && !sts_i.width_ok) |=> (state_q == S_PREP))
    else $error("valid print request not started");
`endif

endmodule

`default_nettype wire

/* design/pgtb_datapath.sv */
// ----------------------------------------------------------------------------
// pgtb_datapath
// Glyph tables, font and palette stores, cursor, font address walk, font
// read pipeline and output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pgtb_datapath import pgtb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [IN_W-1:0]     s_tdata_i,
  input  logic                cfg_we_i,
  input  logic [ROWS_W-1:0]   cfg_wdata_i,
  input  pgtb_cmd_t           cmd_i,
  output pgtb_sts_t           sts_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OUT_W-1:0]    m_tdata_o,
  output logic                m_tlast_o
);

  // request fields
  logic [2:0]  in_action;
  logic [12:0] in_idx;
  logic [15:0] in_value;
  logic [7:0]  in_px;
  logic [7:0]  in_py;
  logic [7:0]  in_code;
  logic [WIDX_W-1:0] in_glyph;
  logic        width_ok;
  logic        print_ok;

  assign in_action = s_tdata_i[2:0];
  assign in_idx    = s_tdata_i[15:3];
  assign in_value  = s_tdata_i[31:16];
  assign in_px     = s_tdata_i[39:32];
  assign in_py     = s_tdata_i[47:40];
  assign in_code   = s_tdata_i[55:48];
  assign in_glyph  = WIDX_W'(in_code - 8'(CHAR_FIRST));

  assign width_ok = (in_action == ACT_LOAD_WIDTH) && (int'(in_idx) < GLYPH_COUNT);
  assign print_ok = (in_action == ACT_PRINT) && (int'(in_code) >= CHAR_FIRST) &&
                    ((int'(in_code) - CHAR_FIRST) < GLYPH_COUNT);

  // stores
  logic [WIDTH_W-1:0] wid_mem [GLYPH_COUNT];
  logic [OFF_W-1:0]   off_mem [GLYPH_COUNT+1];
  logic [3:0]         font_mem [FONT_DEPTH];
  logic [15:0]        pal_q [PAL_DEPTH];
  logic [GLYPH_COUNT:0] off_vld_q;

  logic [WIDTH_W-1:0] wid_rd_q;
  logic [OFF_W-1:0]   off_rd_q;
  logic               offv_rd_q;
  logic [OFF_W-1:0]   off_cur;
  logic [OFF_W-1:0]   off_sum;
  logic [OIDX_W-1:0]  off_raddr;
  logic [OIDX_W-1:0]  off_waddr;
  logic [WIDX_W-1:0]  widx_q;
  logic [WIDTH_W-1:0] wclamp_q;
  logic [WIDTH_W-1:0] in_wclamp;
  logic [3:0]         font_rd_q;

  assign in_wclamp = (in_value > 16'(MAX_GLYPH_WIDTH)) ? WIDTH_W'(MAX_GLYPH_WIDTH)
                                                       : in_value[WIDTH_W-1:0];
  assign off_raddr = width_ok ? OIDX_W'(in_idx) : OIDX_W'(in_glyph);
  assign off_cur   = offv_rd_q ? off_rd_q : '0;
  assign off_sum   = off_cur + OFF_W'(wclamp_q);
  assign off_waddr = OIDX_W'(widx_q) + OIDX_W'(1);

  // glyph walk registers
  logic [ROWS_W-1:0]  height_q;
  logic [OFF_W-1:0]   strip_q;
  logic [WIDTH_W-1:0] gw_q;
  logic [ROWS_W-1:0]  rows_q;
  logic [COLB_W-1:0]  colbase_q;
  logic [RAW_W-1:0]   raw_q;
  logic [15:0]        roff_q;

  // cursor
  logic [15:0] tile_base_q, tile_base_d;
  logic [15:0] row_base_q, row_base_d;
  logic [1:0]  nib_q, nib_d;
  logic        half_q, half_d;
  logic [15:0] tb_step;

  assign tb_step = tile_base_q + 16'(TILE_COL_STEP);

  always_comb begin
    tile_base_d = tile_base_q;
    row_base_d  = row_base_q;
    nib_d       = nib_q;
    half_d      = half_q;
    if (cmd_i.accept && (in_action == ACT_SET_CURSOR)) begin
      row_base_d  = {7'd0, in_py, 1'b0};
      tile_base_d = 16'(in_px[7:3]) * 16'(TILE_PITCH);
      nib_d       = in_px[1:0];
      half_d      = in_px[2];
    end else if (cmd_i.col_adv) begin
      nib_d = nib_q + 2'd1;
      if (nib_q == 2'd3) begin
        half_d = ~half_q;
        if (half_q) begin
          if (tb_step == 16'(TILE_WRAP)) begin
            tile_base_d = '0;
            row_base_d  = row_base_q + {11'd0, rows_q, 1'b0} + 16'd4;
          end else begin
            tile_base_d = tb_step;
          end
        end else begin
          tile_base_d = tile_base_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_base_q <= '0;
      row_base_q  <= '0;
      nib_q       <= '0;
      half_q      <= 1'b0;
      height_q    <= ROWS_W'(MAX_ROWS);
      strip_q     <= '0;
      off_vld_q   <= '0;
    end else begin
      tile_base_q <= tile_base_d;
      row_base_q  <= row_base_d;
      nib_q       <= nib_d;
      half_q      <= half_d;
      if (cfg_we_i) begin
        height_q <= cfg_wdata_i;
      end
      if (cmd_i.wr_width) begin
        strip_q              <= off_sum;
        off_vld_q[off_waddr] <= 1'b1;
      end
    end
  end

  // table memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_width) begin
      wid_mem[widx_q]    <= wclamp_q;
      off_mem[off_waddr] <= off_sum;
    end
    if (cmd_i.accept && (width_ok || print_ok)) begin
      off_rd_q  <= off_mem[off_raddr];
      offv_rd_q <= off_vld_q[off_raddr];
    end
    if (cmd_i.accept && print_ok) begin
      wid_rd_q <= wid_mem[in_glyph];
    end
    if (cmd_i.accept) begin
      widx_q   <= WIDX_W'(in_idx);
      wclamp_q <= in_wclamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_action == ACT_LOAD_FONT) && (int'(in_idx) < FONT_DEPTH)) begin
      font_mem[FONT_AW'(in_idx)] <= in_value[3:0];
    end
    if (cmd_i.issue) begin
      font_rd_q <= font_mem[FONT_AW'(raw_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_action == ACT_LOAD_PAL) && (int'(in_idx) < PAL_DEPTH)) begin
      pal_q[in_idx[3:0]] <= in_value;
    end
  end

  // font address walk: column base plus one strip per row
  always_ff @(posedge clk_i) begin
    if (cmd_i.print_init) begin
      gw_q      <= wid_rd_q;
      rows_q    <= (height_q > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : height_q;
      colbase_q <= COLB_W'(off_cur);
      raw_q     <= RAW_W'(off_cur);
      roff_q    <= row_base_q;
    end else if (cmd_i.col_adv) begin
      colbase_q <= colbase_q + COLB_W'(1);
      raw_q     <= RAW_W'(colbase_q) + RAW_W'(1);
      roff_q    <= row_base_d;
    end else if (cmd_i.issue) begin
      raw_q  <= raw_q + RAW_W'(strip_q);
      roff_q <= roff_q + 16'd2;
    end
  end

  // font read stage
  logic        s1_v_q;
  logic [15:0] s1_addr_q;
  logic [1:0]  s1_nib_q;
  logic        s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_addr_q <= tile_base_q + roff_q;
      s1_nib_q  <= nib_q;
      s1_last_q <= cmd_i.last;
    end
  end

  // output queue
  pgtb_wr_t           fifo_q [FIFO_DEPTH];
  pgtb_wr_t           push_wr;
  pgtb_wr_t           head_wr;
  logic [FIFO_AW-1:0] wp_q;
  logic [FIFO_AW-1:0] rp_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               pop;

  assign push_wr.last     = s1_last_q;
  assign push_wr.or_value = pal_q[font_rd_q] << {s1_nib_q, 2'b00};
  assign push_wr.addr     = s1_addr_q;
  assign head_wr          = fifo_q[rp_q];
  assign m_tvalid_o       = (cnt_q != '0);
  assign pop              = m_tvalid_o && m_tready_i;
  assign m_tdata_o        = {head_wr.or_value, head_wr.addr};
  assign m_tlast_o        = head_wr.last;

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      fifo_q[wp_q] <= push_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (s1_v_q) begin
        wp_q <= wp_q + FIFO_AW'(1);
      end
      if (pop) begin
        rp_q <= rp_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + FIFO_CW'(s1_v_q) - FIFO_CW'(pop);
    end
  end

  assign sts_o.width_ok = width_ok;
  assign sts_o.print_ok = print_ok;
  assign sts_o.glyph_w  = gw_q;
  assign sts_o.rows     = rows_q;
  assign sts_o.room     = (cnt_q + FIFO_CW'(s1_v_q)) < FIFO_CW'(FIFO_DEPTH);

`ifndef SYNTH
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("output queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (cnt_q != FIFO_CW'(FIFO_DEPTH)) || pop)
    else $error("write pushed into full output queue");

  a_half_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.col_adv && (nib_q == 2'd3)) |=> (half_q != $past(half_q)))
    else $error("halfword select did not toggle at nibble wrap");
`endif

endmodule

`default_nettype wire

/* design/proportional_glyph_tile_blitter.sv */
// ----------------------------------------------------------------------------
// proportional_glyph_tile_blitter
// Renders proportional glyphs as OR-writes into column-ordered 4bpp tiles.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: request fields
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: address, value; tlast
//  cfg       in   cfg_we_i                     cfg_wdata_i: glyph height
//
//  width loads add a table-write state; print adds a setup state, then
//  one write per cycle while the queue has room (w*height), or w column steps
//  for zero height; a 4-deep output queue paces issue against m_axis_tready
//  no clearing pass after reset: offset table entries carry valid bits
//  a stalled m_axis holds the walk once the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module proportional_glyph_tile_blitter import pgtb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // action, table_index, load_value, pos_x, pos_y, char_code
  input  logic [IN_W-1:0]     s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // write_address, or_value
  output logic [OUT_W-1:0]    m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [ROWS_W-1:0]   cfg_wdata_i
);

  pgtb_cmd_t cmd;
  pgtb_sts_t sts;

  pgtb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pgtb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* test/proportional_glyph_tile_blitter_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// proportional_glyph_tile_blitter_test
// Self-checking bench for the glyph tile blitter. Requests carry width,
// font and palette loads, cursor moves and prints. Each accepted request
// goes into a scoreboard that predicts every tile OR-write. Each write is
// compared in order against that prediction. Both stream sides idle and
// stall at random. The glyph height is changed between phases while the
// blitter is idle.
// ----------------------------------------------------------------------------

module proportional_glyph_tile_blitter_test;
  import pgtb_pkg::*;

  localparam int          CYCLE_LIMIT      = 1000000;
  localparam int          SETTLE_CYCLES    = 32;
  localparam int          INDEX_MAX        = 8191;
  localparam logic [2:0]  ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  ACT_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic [2:0]  action;
    logic [12:0] index;
    logic [15:0] value;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [7:0]  code;
  } blit_req_t;

  class glyph_blit_scoreboard;
    logic [3:0]  widths[GLYPH_COUNT];
    bit          width_set[GLYPH_COUNT];
    logic [9:0]  offsets[GLYPH_COUNT+1];
    logic [9:0]  strip;
    logic [3:0]  font[FONT_DEPTH];
    bit          font_set[FONT_DEPTH];
    logic [15:0] palette[PAL_DEPTH];
    bit          pal_set[PAL_DEPTH];
    logic [15:0] tile_base;
    logic [15:0] row_base;
    logic [1:0]  nibble;
    bit          upper_half;
    logic [3:0]  height;
    pgtb_wr_t    pending[$];
    int          errors;

    function new();
      foreach (offsets[i]) offsets[i] = '0;
      strip      = '0;
      tile_base  = '0;
      row_base   = '0;
      nibble     = '0;
      upper_half = 1'b0;
      height     = 4'd8;
      errors     = 0;
    endfunction

    function int unsigned active_rows();
      return (height > MAX_ROWS) ? MAX_ROWS : height;
    endfunction

    function int unsigned font_addr(int unsigned g, int unsigned a, int unsigned b);
      return (b * strip + a + offsets[g]) % FONT_DEPTH;
    endfunction

    function void step_column(int unsigned rows);
      if (nibble == 2'd3) begin
        nibble = 2'd0;
        if (upper_half) begin
          tile_base = tile_base + 16'(TILE_COL_STEP);
          if (tile_base == 16'(TILE_WRAP)) begin
            tile_base = '0;
            row_base  = row_base + 16'(rows * 2 + 4);
          end
        end else begin
          tile_base = tile_base + 16'd1;
        end
        upper_half = !upper_half;
      end else begin
        nibble = nibble + 2'd1;
      end
    endfunction

    function void note_request(blit_req_t r);
      int unsigned w, g, rows, total, count, fa, a, b;
      logic [9:0]  sum;
      pgtb_wr_t    wr;
      case (r.action)
        ACT_LOAD_WIDTH: begin
          if (r.index < GLYPH_COUNT) begin
            w = (r.value > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : r.value;
            sum = offsets[r.index] + w[9:0];
            widths[r.index]    = w[3:0];
            width_set[r.index] = 1'b1;
            offsets[r.index+1] = sum;
            strip              = sum;
          end
        end
        ACT_LOAD_FONT: begin
          if (r.index < FONT_DEPTH) begin
            font[r.index]     = r.value[3:0];
            font_set[r.index] = 1'b1;
          end
        end
        ACT_LOAD_PAL: begin
          if (r.index < PAL_DEPTH) begin
            palette[r.index] = r.value;
            pal_set[r.index] = 1'b1;
          end
        end
        ACT_SET_CURSOR: begin
          row_base   = {7'd0, r.py, 1'b0};
          tile_base  = 16'(r.px[7:3] * TILE_PITCH);
          nibble     = r.px[1:0];
          upper_half = r.px[2];
        end
        ACT_PRINT: begin
          if (r.code >= CHAR_FIRST && r.code < CHAR_FIRST + GLYPH_COUNT) begin
            g     = r.code - CHAR_FIRST;
            w     = widths[g];
            rows  = active_rows();
            total = w * rows;
            count = 0;
            for (a = 0; a < w; a++) begin
              for (b = 0; b < rows; b++) begin
                fa          = font_addr(g, a, b);
                wr.addr     = tile_base + row_base + 16'(2 * b);
                wr.or_value = 16'(32'(palette[font[fa]]) << (4 * nibble));
                count++;
                wr.last     = (count == total);
                pending.push_back(wr);
              end
              step_column(rows);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_write(pgtb_wr_t got);
      pgtb_wr_t want;
      if (pending.size() == 0) begin
        $error("unexpected write: write_address %h or_value %h last_write %b",
               got.addr, got.or_value, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.addr !== want.addr) begin
        $error("write_address: expected %h, got %h", want.addr, got.addr);
        errors++;
      end
      if (got.or_value !== want.or_value) begin
        $error("or_value: expected %h, got %h", want.or_value, got.or_value);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_write: expected %b, got %b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_n     = 1'b0;
  logic              s_valid   = 1'b0;
  logic [IN_W-1:0]   s_data    = '0;
  logic              m_ready   = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [ROWS_W-1:0] cfg_wdata = '0;
  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  glyph_blit_scoreboard sb;
  int                   cycle_count = 0;
  int                   last_gap    = 1;
  int                   steady_left = 0;
  int unsigned          ready_hold  = 0;
  int unsigned          ready_pick;
  int unsigned          next_glyph  = 0;

  proportional_glyph_tile_blitter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // write sink: short and long stalls, plus long stretches of steady ready
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 50) begin
        m_ready    <= 1'b1;
        ready_hold <= $urandom_range(0, 6);
      end else if (ready_pick < 60) begin
        m_ready    <= 1'b1;
        ready_hold <= $urandom_range(40, 150);
      end else if (ready_pick < 93) begin
        m_ready    <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        m_ready    <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    pgtb_wr_t got;
    if (rst_n && m_axis_tvalid && m_ready) begin
      got.addr     = m_axis_tdata[15:0];
      got.or_value = m_axis_tdata[31:16];
      got.last     = m_axis_tlast;
      sb.check_write(got);
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      steady_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic blit_req_t noise_req(logic [2:0] act);
    blit_req_t r;
    r.action = act;
    r.index  = 13'($urandom);
    r.value  = 16'($urandom);
    r.px     = 8'($urandom);
    r.py     = 8'($urandom);
    r.code   = 8'($urandom);
    return r;
  endfunction

  function automatic int unsigned pick_glyph();
    int unsigned known[$];
    foreach (sb.width_set[i]) if (sb.width_set[i]) known.push_back(i);
    return known[$urandom_range(0, known.size() - 1)];
  endfunction

  task automatic send_request(blit_req_t r);
    int gap;
    s_valid <= 1'b1;
    s_data  <= {r.code, r.py, r.px, r.value, r.index, r.action};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r);
    gap = pick_gap();
    last_gap = gap;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_width(int unsigned idx, int unsigned val);
    blit_req_t r;
    r = noise_req(ACT_LOAD_WIDTH);
    r.index = 13'(idx);
    r.value = 16'(val);
    send_request(r);
  endtask

  task automatic load_font(int unsigned addr, int unsigned val);
    blit_req_t r;
    r = noise_req(ACT_LOAD_FONT);
    r.index = 13'(addr);
    r.value = 16'(val);
    send_request(r);
  endtask

  task automatic load_palette(int unsigned idx, int unsigned val);
    blit_req_t r;
    r = noise_req(ACT_LOAD_PAL);
    r.index = 13'(idx);
    r.value = 16'(val);
    send_request(r);
  endtask

  task automatic set_cursor(int unsigned x, int unsigned y);
    blit_req_t r;
    r = noise_req(ACT_SET_CURSOR);
    r.px = 8'(x);
    r.py = 8'(y);
    send_request(r);
  endtask

  task automatic print_char(int unsigned code);
    blit_req_t r;
    r = noise_req(ACT_PRINT);
    r.code = 8'(code);
    send_request(r);
  endtask

  // fill every font pixel and palette entry the glyph will read, then print it
  task automatic print_glyph(int unsigned g);
    int unsigned rows, w, fa, a, b;
    rows = sb.active_rows();
    w    = sb.widths[g];
    for (a = 0; a < w; a++) begin
      for (b = 0; b < rows; b++) begin
        fa = sb.font_addr(g, a, b);
        if (!sb.font_set[fa]) load_font(fa, $urandom_range(0, 65535));
      end
    end
    for (a = 0; a < w; a++) begin
      for (b = 0; b < rows; b++) begin
        fa = sb.font_addr(g, a, b);
        if (!sb.pal_set[sb.font[fa]]) load_palette(sb.font[fa], $urandom_range(0, 65535));
      end
    end
    print_char(g + CHAR_FIRST);
  endtask

  task automatic drain_writes();
    if (last_gap == 0) s_valid <= 1'b0;
    last_gap = 1;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_items(int n);
    int unsigned pick, k, val;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        print_glyph(pick_glyph());
      end else if (pick < 50) begin
        if ($urandom_range(0, 2) == 0) set_cursor($urandom_range(224, 239), $urandom_range(0, 255));
        else set_cursor($urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick < 62) begin
        k   = $urandom_range(0, 99);
        val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, MAX_GLYPH_WIDTH);
        if (k < 70) begin
          load_width(next_glyph, val);
          next_glyph = (next_glyph + 1) % GLYPH_COUNT;
        end else if (k < 85) begin
          load_width($urandom_range(0, GLYPH_COUNT - 1), val);
        end else begin
          load_width($urandom_range(GLYPH_COUNT, INDEX_MAX), val);
        end
      end else if (pick < 70) begin
        if ($urandom_range(0, 3) == 0) load_palette($urandom_range(PAL_DEPTH, INDEX_MAX),
                                                    $urandom_range(0, 65535));
        else load_palette($urandom_range(0, PAL_DEPTH - 1), $urandom_range(0, 65535));
      end else if (pick < 78) begin
        load_font($urandom_range(0, INDEX_MAX), $urandom_range(0, 65535));
      end else if (pick < 90) begin
        if ($urandom_range(0, 1) == 0) print_char($urandom_range(0, CHAR_FIRST - 1));
        else print_char($urandom_range(CHAR_FIRST + GLYPH_COUNT, 255));
      end else if (pick < 95) begin
        send_request(noise_req(3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST))));
      end else begin
        k = $urandom_range(3, 6);
        repeat (k) print_glyph(pick_glyph());
      end
    end
  endtask

  initial begin
    logic [3:0] phase_heights[6];
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // widths in ascending order, clamped and ignored indexes
    load_width(0, 16'hFFFF);
    load_width(1, 1);
    load_width(2, 0);
    load_width(3, 9);
    load_width(4, 5);
    load_width(GLYPH_COUNT, 3);
    load_width(INDEX_MAX, 8);
    load_palette(PAL_DEPTH, 16'hFFFF);
    load_palette(INDEX_MAX, 16'h0000);
    load_palette(PAL_DEPTH - 1, 16'hFFFF);
    load_font(INDEX_MAX, 16'hFFFF);
    set_cursor(0, 0);
    print_glyph(0);
    // wraps downward partway through the glyph
    set_cursor(235, 255);
    print_glyph(0);
    set_cursor(255, 128);
    print_glyph(3);
    print_glyph(1);
    print_glyph(2);
    print_char(0);
    print_char(CHAR_FIRST - 1);
    print_char(CHAR_FIRST + GLYPH_COUNT);
    print_char(255);
    send_request(noise_req(ACT_UNUSED_FIRST));
    send_request(noise_req(3'd6));
    send_request(noise_req(ACT_UNUSED_LAST));
    // out of order load, then the ascending chain resumes
    load_width(GLYPH_COUNT - 1, 7);
    print_glyph(GLYPH_COUNT - 1);
    load_width(5, 4);
    next_glyph = 6;

    phase_heights = '{4'd1, 4'd15, 4'd0, 4'd5, 4'd9, 4'd8};
    phase_heights[3] = 4'($urandom_range(2, 7));
    foreach (phase_heights[p]) begin
      drain_writes();
      cfg_we    <= 1'b1;
      cfg_wdata <= phase_heights[p];
      @(posedge clk_i);
      cfg_we    <= 1'b0;
      sb.height = phase_heights[p];
      random_items(25);
    end
    drain_writes();

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
